[rtl/sweep_sync_pulse_tracker_defines.svh]
// Assertion macros shared by the sweep sync pulse tracker modules.
`ifndef SWEEP_SYNC_PULSE_TRACKER_DEFINES_SVH
`define SWEEP_SYNC_PULSE_TRACKER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SSPT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SSPT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sspt_pkg.sv]
// Types, constants and codes shared by the sweep sync pulse tracker.
package sspt_pkg;

    // Timer width used for pulse widths and sweep deltas.
    localparam int TIME_BITS = 32;
    localparam int FIELD_W   = 32;

    // Configuration registers.
    localparam int BIAS_W        = 10;
    localparam int JUMP_W        = 20;
    localparam int CFG_DATA_W    = 20;
    localparam int CFG_INDEX_W   = 1;
    localparam logic [JUMP_W-1:0] JUMP_LIMIT_RESET = JUMP_W'(4630);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WIDTH_BIAS = 1'b0,
        REG_JUMP_LIMIT = 1'b1
    } reg_index_t;

    // Width scaling: (diff * 924 mod 2^32) / 1000, the divide done by reciprocal.
    localparam int SCALE_W = 10;
    localparam logic [SCALE_W-1:0] SCALE_MUL = SCALE_W'(924);
    localparam int MAGIC_W = 29;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = MAGIC_W'(274877907);
    localparam int DIV_SHIFT = 38;
    localparam int WIDTH_W   = 23;

    // Band edges before the bias is added.
    localparam int EDGE_LASER_LO = 100;
    localparam int EDGE_AZ1_LO   = 585;
    localparam int EDGE_EL1_LO   = 675;
    localparam int EDGE_AZ2_LO   = 781;
    localparam int EDGE_EL2_LO   = 885;
    localparam int EDGE_AZS1_LO  = 989;
    localparam int EDGE_ELS1_LO  = 1083;
    localparam int EDGE_AZS2_LO  = 1200;
    localparam int EDGE_ELS2_LO  = 1300;
    localparam int EDGE_TOP      = 1400;

    // Delta comparison widths.
    localparam int DIFF_W = TIME_BITS + 1;
    localparam int CMP_W  = (DIFF_W > JUMP_W) ? DIFF_W : JUMP_W;

    typedef enum logic [2:0] {
        K_INVALID = 3'd0,
        K_LASER   = 3'd1,
        K_AZ      = 3'd2,
        K_EL      = 3'd3,
        K_AZ_SKIP = 3'd4,
        K_EL_SKIP = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'd0,
        PH_A_SYNC  = 3'd1,
        PH_B_SKIP  = 3'd2,
        PH_A_SWEEP = 3'd3,
        PH_B_SWEEP = 3'd4
    } phase_t;

    typedef struct packed {
        logic [FIELD_W-1:0] rise_time;
        logic [FIELD_W-1:0] fall_time;
    } pulse_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] sync_stamp;
        logic [FIELD_W-1:0] sweep_stamp;
        logic               from_b;
        logic               is_elevation;
    } sweep_out_t;

    // Classified pulse leaving the front pipeline.
    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] rise;
        kind_t              kind;
    } pulse_item_t;

    // Sweep report from one axis tracker.
    typedef struct packed {
        logic               fire;
        logic               from_b;
        logic [FIELD_W-1:0] sync;
    } axis_fire_t;

endpackage

[rtl/sspt_front.sv]
// Front pipeline: pulse width scaling, reciprocal divide and band classification.
module sspt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sspt_pkg::pulse_in_t           in_data,
    input  logic [sspt_pkg::BIAS_W-1:0]   band_offset,
    input  logic                          drain,
    output sspt_pkg::pulse_item_t         item
);

    // Band edge moved up by the bias.
    function automatic logic [sspt_pkg::WIDTH_W-1:0] band_edge(
        input int                          base,
        input logic [sspt_pkg::BIAS_W-1:0] bias
    );
        return sspt_pkg::WIDTH_W'(base) + sspt_pkg::WIDTH_W'(bias);
    endfunction

    // Sort a pulse width into its band; the bands do not overlap.
    function automatic sspt_pkg::kind_t classify(
        input logic [sspt_pkg::WIDTH_W-1:0] w,
        input logic [sspt_pkg::BIAS_W-1:0]  b
    );
        sspt_pkg::kind_t k;
        k = sspt_pkg::K_INVALID;
        if (w > band_edge(sspt_pkg::EDGE_LASER_LO, b) && w < band_edge(sspt_pkg::EDGE_AZ1_LO, b))
            k = sspt_pkg::K_LASER;
        if (w > band_edge(sspt_pkg::EDGE_AZ1_LO, b) && w < band_edge(sspt_pkg::EDGE_EL1_LO, b))
            k = sspt_pkg::K_AZ;
        if (w >= band_edge(sspt_pkg::EDGE_EL1_LO, b) && w < band_edge(sspt_pkg::EDGE_AZ2_LO, b))
            k = sspt_pkg::K_EL;
        if (w >= band_edge(sspt_pkg::EDGE_AZ2_LO, b) && w < band_edge(sspt_pkg::EDGE_EL2_LO, b))
            k = sspt_pkg::K_AZ;
        if (w >= band_edge(sspt_pkg::EDGE_EL2_LO, b) && w < band_edge(sspt_pkg::EDGE_AZS1_LO, b))
            k = sspt_pkg::K_EL;
        if (w >= band_edge(sspt_pkg::EDGE_AZS1_LO, b) && w < band_edge(sspt_pkg::EDGE_ELS1_LO, b))
            k = sspt_pkg::K_AZ_SKIP;
        if (w >= band_edge(sspt_pkg::EDGE_ELS1_LO, b) && w < band_edge(sspt_pkg::EDGE_AZS2_LO, b))
            k = sspt_pkg::K_EL_SKIP;
        if (w >= band_edge(sspt_pkg::EDGE_AZS2_LO, b) && w < band_edge(sspt_pkg::EDGE_ELS2_LO, b))
            k = sspt_pkg::K_AZ_SKIP;
        if (w >= band_edge(sspt_pkg::EDGE_ELS2_LO, b) && w < band_edge(sspt_pkg::EDGE_TOP, b))
            k = sspt_pkg::K_EL_SKIP;
        return k;
    endfunction

    // Stage valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // Stage payloads.
    logic [sspt_pkg::FIELD_W-1:0] rise1_reg, fall1_reg;
    logic [sspt_pkg::FIELD_W-1:0] rise2_reg, prod2_reg;
    logic [sspt_pkg::FIELD_W-1:0] rise3_reg;
    logic [sspt_pkg::WIDTH_W-1:0] width3_reg;
    logic [sspt_pkg::FIELD_W-1:0] rise4_reg;
    sspt_pkg::kind_t              kind4_reg;

    logic [sspt_pkg::TIME_BITS-1:0]                  diff;
    logic [sspt_pkg::FIELD_W+sspt_pkg::SCALE_W-1:0]  prod_next;
    logic [sspt_pkg::FIELD_W+sspt_pkg::MAGIC_W-1:0]  quot_wide;
    sspt_pkg::kind_t                                 kind_next;

    // A stage takes a new transaction when it is empty or its content moves on.
    assign rdy4     = !v4_reg || drain;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Timer difference modulo the timer width, scaled by 924 modulo 2^32.
    assign diff      = fall1_reg[sspt_pkg::TIME_BITS-1:0] - rise1_reg[sspt_pkg::TIME_BITS-1:0];
    assign prod_next = sspt_pkg::FIELD_W'(diff) * sspt_pkg::SCALE_MUL;

    // Divide by 1000 through the reciprocal; exact for every 32-bit dividend.
    assign quot_wide = prod2_reg * sspt_pkg::DIV_MAGIC;

    assign kind_next = classify(width3_reg, band_offset);

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            rise1_reg <= in_data.rise_time;
            fall1_reg <= in_data.fall_time;
        end
        if (rdy2)
        begin
            rise2_reg <= rise1_reg;
            prod2_reg <= prod_next[sspt_pkg::FIELD_W-1:0];
        end
        if (rdy3)
        begin
            rise3_reg  <= rise2_reg;
            width3_reg <= quot_wide[sspt_pkg::DIV_SHIFT +: sspt_pkg::WIDTH_W];
        end
        if (rdy4)
        begin
            rise4_reg <= rise3_reg;
            kind4_reg <= kind_next;
        end
    end

    assign item.valid = v4_reg;
    assign item.rise  = rise4_reg;
    assign item.kind  = kind4_reg;

endmodule

[rtl/sspt_axis.sv]
// One axis tracker: follows sync, skip and sweep pulses and judges each sweep.
`include "sweep_sync_pulse_tracker_defines.svh"

module sspt_axis (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  sspt_pkg::kind_t               kind,
    input  logic [sspt_pkg::FIELD_W-1:0]  rise,
    input  logic [sspt_pkg::JUMP_W-1:0]   jump_limit,
    input  sspt_pkg::kind_t               sync_kind,
    input  sspt_pkg::kind_t               skip_kind,
    output sspt_pkg::axis_fire_t          fire_info
);

    sspt_pkg::phase_t               phase_reg, phase_next;
    logic [sspt_pkg::FIELD_W-1:0]   sync_a_reg, sync_b_reg;
    logic [sspt_pkg::TIME_BITS-1:0] delta_a_reg, delta_b_reg;

    logic is_sync, is_skip, is_laser;
    logic sweep_b;
    logic load_a, load_b, load_delta, fire;
    logic [sspt_pkg::FIELD_W-1:0]   sel_sync;
    logic [sspt_pkg::TIME_BITS-1:0] sel_delta, new_delta;
    logic signed [sspt_pkg::DIFF_W-1:0] delta_diff;
    logic [sspt_pkg::DIFF_W-1:0]    delta_mag;
    logic                           judge_ok;

    assign is_sync  = (kind == sync_kind);
    assign is_skip  = (kind == skip_kind);
    assign is_laser = (kind == sspt_pkg::K_LASER);

    // Sweep judgment: exact signed change of the delta against the jump limit.
    assign sweep_b    = (phase_reg == sspt_pkg::PH_B_SWEEP);
    assign sel_sync   = sweep_b ? sync_b_reg : sync_a_reg;
    assign sel_delta  = sweep_b ? delta_b_reg : delta_a_reg;
    assign new_delta  = rise[sspt_pkg::TIME_BITS-1:0] - sel_sync[sspt_pkg::TIME_BITS-1:0];
    assign delta_diff = $signed({new_delta[sspt_pkg::TIME_BITS-1], new_delta})
                      - $signed({sel_delta[sspt_pkg::TIME_BITS-1], sel_delta});
    assign delta_mag  = delta_diff[sspt_pkg::DIFF_W-1] ? sspt_pkg::DIFF_W'(-delta_diff)
                                                       : sspt_pkg::DIFF_W'(delta_diff);
    assign judge_ok   = (sel_delta != '0)
                     && (sspt_pkg::CMP_W'(delta_mag) < sspt_pkg::CMP_W'(jump_limit));

    // Phase register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= sspt_pkg::PH_SEARCH;
        else if (step)
            phase_reg <= phase_next;
    end

    // Next phase and the stores it triggers.
    always_comb
    begin
        phase_next = sspt_pkg::PH_SEARCH;
        load_a     = 1'b0;
        load_b     = 1'b0;
        load_delta = 1'b0;
        fire       = 1'b0;
        unique case (phase_reg)
            sspt_pkg::PH_A_SYNC:
            begin
                priority if (is_sync)
                begin
                    load_a     = 1'b1;
                    phase_next = sspt_pkg::PH_A_SYNC;
                end
                else if (is_skip)
                    phase_next = sspt_pkg::PH_A_SWEEP;
                else
                    phase_next = sspt_pkg::PH_SEARCH;
            end
            sspt_pkg::PH_B_SKIP:
            begin
                priority if (is_sync)
                begin
                    load_b     = 1'b1;
                    phase_next = sspt_pkg::PH_B_SWEEP;
                end
                else if (is_skip)
                    phase_next = sspt_pkg::PH_B_SKIP;
                else
                    phase_next = sspt_pkg::PH_SEARCH;
            end
            sspt_pkg::PH_A_SWEEP, sspt_pkg::PH_B_SWEEP:
            begin
                priority if (is_sync)
                begin
                    load_a     = 1'b1;
                    phase_next = sspt_pkg::PH_A_SYNC;
                end
                else if (is_skip)
                    phase_next = sspt_pkg::PH_B_SKIP;
                else if (is_laser)
                begin
                    load_delta = 1'b1;
                    fire       = judge_ok;
                    phase_next = sspt_pkg::PH_SEARCH;
                end
                else
                    phase_next = sspt_pkg::PH_SEARCH;
            end
            // Searching, and unused codes treated as searching.
            default:
            begin
                priority if (is_sync)
                begin
                    load_a     = 1'b1;
                    phase_next = sspt_pkg::PH_A_SYNC;
                end
                else if (is_skip)
                    phase_next = sspt_pkg::PH_B_SKIP;
                else
                    phase_next = sspt_pkg::PH_SEARCH;
            end
        endcase
    end

    // Sync times and last sweep deltas.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_a_reg  <= '0;
            sync_b_reg  <= '0;
            delta_a_reg <= '0;
            delta_b_reg <= '0;
        end
        else if (step)
        begin
            if (load_a)
                sync_a_reg <= rise;
            if (load_b)
                sync_b_reg <= rise;
            if (load_delta && !sweep_b)
                delta_a_reg <= new_delta;
            if (load_delta && sweep_b)
                delta_b_reg <= new_delta;
        end
    end

    assign fire_info.fire   = step && fire;
    assign fire_info.from_b = sweep_b;
    assign fire_info.sync   = sel_sync;

    `SSPT_ASSERT_NOW(a_fire_in_sweep, clk, rst_n, fire_info.fire,
        phase_reg == sspt_pkg::PH_A_SWEEP || phase_reg == sspt_pkg::PH_B_SWEEP,
        "sweep reported outside a sweep phase")
    `SSPT_ASSERT_NEXT(a_sync_enters, clk, rst_n, step && is_sync,
        phase_reg == sspt_pkg::PH_A_SYNC || phase_reg == sspt_pkg::PH_B_SWEEP,
        "sync pulse did not move the tracker to a sync phase")
    `SSPT_ASSERT_NEXT(a_idle_holds, clk, rst_n, !step,
        $stable(phase_reg) && $stable(delta_a_reg) && $stable(delta_b_reg),
        "tracker state changed without a pulse")

endmodule

[rtl/sweep_sync_pulse_tracker.sv]
// Sweep sync pulse tracker top level: config registers, two axis trackers, result register.
//
// Each accepted transaction is one optical pulse (rise and fall timer counts).
// The block takes one pulse per clock cycle while the output is not stalled. A
// pulse passes four pipeline registers (input, width scaling multiply,
// reciprocal multiply for the divide by 1000, band classification) and then
// updates the azimuth and elevation trackers, from which a sweep report for
// its laser pulse goes into the result register. Pulses that produce no report,
// invalid widths included, leave nothing at the output. A stalled output
// holds the pipeline stage by stage; empty stages keep taking pulses.
// Configuration writes take effect on the next edge and are meant to be
// done while no pulse is in flight.
`include "sweep_sync_pulse_tracker_defines.svh"

module sweep_sync_pulse_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sspt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sspt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sspt_pkg::pulse_in_t               in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sspt_pkg::sweep_out_t              out_data
);

    logic [sspt_pkg::BIAS_W-1:0] band_offset_reg;
    logic [sspt_pkg::JUMP_W-1:0] jump_limit_reg;

    sspt_pkg::pulse_item_t item;
    sspt_pkg::axis_fire_t  az_info, el_info;
    logic                  out_free, consume, step;
    logic                  out_valid_reg;
    sspt_pkg::sweep_out_t  out_data_reg, out_data_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_offset_reg <= '0;
            jump_limit_reg  <= sspt_pkg::JUMP_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (sspt_pkg::reg_index_t'(cfg_index))
                sspt_pkg::REG_WIDTH_BIAS: band_offset_reg <= cfg_data[sspt_pkg::BIAS_W-1:0];
                sspt_pkg::REG_JUMP_LIMIT: jump_limit_reg <= cfg_data[sspt_pkg::JUMP_W-1:0];
                default: ;
            endcase
        end
    end

    // The last stage moves on when the result register is free.
    assign out_free = !out_valid_reg || out_ready;
    assign consume  = item.valid && out_free;
    assign step     = consume && (item.kind != sspt_pkg::K_INVALID);

    sspt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .band_offset (band_offset_reg),
        .drain       (out_free),
        .item        (item)
    );

    sspt_axis u_az (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .kind       (item.kind),
        .rise       (item.rise),
        .jump_limit (jump_limit_reg),
        .sync_kind  (sspt_pkg::K_AZ),
        .skip_kind  (sspt_pkg::K_AZ_SKIP),
        .fire_info  (az_info)
    );

    sspt_axis u_el (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .kind       (item.kind),
        .rise       (item.rise),
        .jump_limit (jump_limit_reg),
        .sync_kind  (sspt_pkg::K_EL),
        .skip_kind  (sspt_pkg::K_EL_SKIP),
        .fire_info  (el_info)
    );

    // Result selection; azimuth wins if both trackers report.
    always_comb
    begin
        out_data_next.sweep_stamp = item.rise;
        if (az_info.fire)
        begin
            out_data_next.sync_stamp   = az_info.sync;
            out_data_next.from_b       = az_info.from_b;
            out_data_next.is_elevation = 1'b0;
        end
        else
        begin
            out_data_next.sync_stamp   = el_info.sync;
            out_data_next.from_b       = el_info.from_b;
            out_data_next.is_elevation = 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= az_info.fire || el_info.fire;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SSPT_ASSERT_NEXT(a_no_spurious_out, clk, rst_n,
        out_free && !(az_info.fire || el_info.fire), !out_valid_reg,
        "result transaction without a reported sweep")
    `SSPT_ASSERT_NOW(a_one_tracker, clk, rst_n, consume, !(az_info.fire && el_info.fire),
        "both trackers reported the same pulse")
    `SSPT_ASSERT_NEXT(a_az_result, clk, rst_n, consume && az_info.fire,
        out_valid_reg && !out_data_reg.is_elevation,
        "azimuth sweep not delivered as an azimuth result")

endmodule
